// File: hdl/lwtm_pkg.sv
`timescale 1ns / 1ps

package lwtm_pkg;

    // Channel format and luminance
    localparam int CHAN_W     = 24;
    localparam int P_W        = 5;
    localparam int COUNT_W    = 24;
    localparam int MAX_PIXELS = 1048576;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_PIXELS < 16777215) ? COUNT_W'(MAX_PIXELS) : 24'hFFFFFF;

    // Luminance weights in Q16
    localparam logic [15:0] W_C0 = 16'd17695;
    localparam logic [15:0] W_C1 = 16'd43909;
    localparam logic [15:0] W_C2 = 16'd3932;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Serial divider width
    localparam int DIV_W = 64;

    // Configuration port
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE = 2'd1;
    localparam logic [CFG_W-1:0] KEY_RESET   = 16'd737;
    localparam logic [CFG_W-1:0] WHITE_RESET = 16'd256;

    localparam logic [39:0] CAP40 = 40'hFF_FFFF_FFFF;

    localparam logic CMD_STAT = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [CHAN_W-1:0] chan_zero;
        logic [CHAN_W-1:0] chan_one;
        logic [CHAN_W-1:0] chan_two;
        logic [7:0]        white_factor;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_zero;
        logic [7:0] out_one;
        logic [7:0] out_two;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        in_item_t          item;
        logic [CHAN_W-1:0] lum;
    } queue_item_t;

    // Q30 roots 2^(2^-k), k = 1..16, each the integer square root of the last
    function automatic logic [511:0] root_table();
        logic [511:0] tbl;
        logic [63:0]  x;
        logic [63:0]  res;
        logic [63:0]  bv;
        logic [63:0]  r;
        tbl = '0;
        r   = '0;
        for (int k = 0; k < 16; k++) begin
            x   = (k == 0) ? (64'd2 << 60) : (r << 30);
            res = '0;
            bv  = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (x >= res + bv) begin
                    x   = x - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
            r = res;
            tbl[k*32 +: 32] = r[31:0];
        end
        return tbl;
    endfunction

    localparam logic [511:0] ROOT_TBL = root_table();

endpackage

// File: hdl/lwtm_front.sv
`timescale 1ns / 1ps

module lwtm_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lwtm_pkg::in_item_t    s_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output lwtm_pkg::queue_item_t push_data
);

    localparam int SUM_W = lwtm_pkg::CHAN_W + 18;

    logic               hold_valid_reg;
    lwtm_pkg::in_item_t hold_reg;
    logic [SUM_W-1:0]   luma_sum;

    assign s_ready    = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;

    // weighted luminance, rounded from Q16
    assign luma_sum = SUM_W'(lwtm_pkg::W_C0) * SUM_W'(hold_reg.chan_zero)
                    + SUM_W'(lwtm_pkg::W_C1) * SUM_W'(hold_reg.chan_one)
                    + SUM_W'(lwtm_pkg::W_C2) * SUM_W'(hold_reg.chan_two)
                    + SUM_W'(32768);

    assign push_data.item = hold_reg;
    assign push_data.lum  = luma_sum[16 +: lwtm_pkg::CHAN_W];

    // input stage: takes a transfer whenever the stage is free or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_reg <= s_data;
        end
    end

endmodule

// File: hdl/lwtm_fifo.sv
`timescale 1ns / 1ps

module lwtm_fifo #(
    parameter int DEPTH = lwtm_pkg::FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  lwtm_pkg::queue_item_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output lwtm_pkg::queue_item_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lwtm_pkg::queue_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/lwtm_div.sv
`timescale 1ns / 1ps

module lwtm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lwtm_pkg::DIV_W-1:0] dividend,
    input  logic [lwtm_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [lwtm_pkg::DIV_W-1:0] quotient
);

    localparam int W     = lwtm_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     dvd_reg;
    logic [W-1:0]     dsr_reg;
    logic [W-1:0]     rem_reg;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign shifted  = {rem_reg, dvd_reg[W-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign fits     = !diff[W];
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
            dvd_reg <= {dvd_reg[W-2:0], fits};
        end
    end

endmodule

// File: hdl/lwtm_back.sv
`timescale 1ns / 1ps

module lwtm_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lwtm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lwtm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  lwtm_pkg::queue_item_t            q_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lwtm_pkg::out_item_t              m_data
);

    localparam int CW = lwtm_pkg::CHAN_W;
    localparam int PW = lwtm_pkg::P_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_STAT, ST_LOG, ST_ACC, ST_CLOSE, ST_MEAN_WAIT, ST_EXP, ST_KEY,
        ST_WS_GO, ST_WS_WAIT, ST_LW, ST_AL, ST_D1_GO, ST_D1_WAIT, ST_KQ_GO,
        ST_KQ_WAIT, ST_LD_GO, ST_LD_WAIT, ST_H_GO, ST_H_WAIT, ST_PP, ST_R, ST_CH,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    lwtm_pkg::queue_item_t item_reg;
    logic [15:0]           key_reg;
    logic [15:0]           white_reg;
    logic [CW-1:0]         max_reg;
    logic signed [47:0]    lsum_reg;
    logic [lwtm_pkg::COUNT_W-1:0] cnt_reg;
    logic [31:0]           gain_reg;
    logic [31:0]           ws_reg;
    logic [31:0]           m_reg;
    logic [PW-1:0]         p_reg;
    logic [15:0]           frac_reg;
    logic [3:0]            iter_reg;
    logic [23:0]           n_reg;
    logic [39:0]           lw_reg;
    logic [39:0]           al_reg;
    logic [39:0]           d1_reg;
    logic [39:0]           kq_reg;
    logic [63:0]           ld_reg;
    logic [63:0]           h_reg;
    logic [95:0]           acc_reg;
    logic [28:0]           r_reg;
    lwtm_pkg::out_item_t   res_reg;
    logic                  m_valid_reg;
    lwtm_pkg::out_item_t   m_data_reg;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic          div_start;
    logic [63:0]   div_dvd;
    logic [63:0]   div_dsr;
    logic          div_done;
    logic [63:0]   div_q;
    logic [PW-1:0] msb;
    logic [31:0]   norm;
    logic          ls_neg;
    logic [47:0]   ls_mag;
    logic [31:0]   sq;
    logic [6:0]    log_ip;
    logic [47:0]   log_val;
    logic signed [7:0] exp_ip;
    logic signed [8:0] exp_s;
    logic [63:0]   exp_rnd;
    logic [56:0]   al_sum;
    logic [44:0]   al_sh;
    logic [6:0]    pp_sh;
    logic [95:0]   pp_ext;
    logic [35:0]   ch_t;
    logic [7:0]    ch_o;
    logic [CW-1:0] ch_c;

    function automatic logic [39:0] cap40(input logic [63:0] v);
        return (v[63:40] != '0) ? lwtm_pkg::CAP40 : v[39:0];
    endfunction

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;

    // leading one of the luminance and the Q30 mantissa
    always_comb begin
        msb = '0;
        for (int i = 0; i < CW; i++) begin
            if (item_reg.lum[i]) begin
                msb = PW'(i);
            end
        end
    end
    assign norm = 32'(item_reg.lum) << (PW'(30) - msb);

    assign ls_neg  = lsum_reg[47];
    assign ls_mag  = ls_neg ? 48'(-lsum_reg) : 48'(lsum_reg);
    assign sq      = mul_p[61:30];
    assign log_ip  = $signed({2'b00, p_reg}) - 7'sd12;
    assign log_val = {{25{log_ip[6]}}, log_ip, frac_reg};

    assign exp_ip  = $signed(n_reg[23:16]);
    assign exp_s   = 9'sd26 - {exp_ip[7], exp_ip};
    assign exp_rnd = (mul_p + (64'd1 << (exp_s[5:0] - 6'd1))) >> exp_s[5:0];

    assign al_sum = 57'(mul_p[55:0]) + 57'd2048;
    assign al_sh  = al_sum[56:12];

    assign pp_sh  = (iter_reg == 4'd0) ? 7'd0 : ((iter_reg == 4'd3) ? 7'd64 : 7'd32);
    assign pp_ext = {32'b0, mul_p} << pp_sh;

    // channel: 255 * r * c, rounded from Q28, clamped
    assign ch_t = {mul_p[27:0], 8'b0} - {8'b0, mul_p[27:0]} + 36'd134217728;
    assign ch_o = (mul_p[52:28] != '0) ? 8'd255 : ch_t[35:28];

    always_comb begin
        case (iter_reg)
            4'd0:    ch_c = item_reg.item.chan_zero;
            4'd1:    ch_c = item_reg.item.chan_one;
            default: ch_c = item_reg.item.chan_two;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOG: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_EXP: begin
                mul_a = m_reg;
                mul_b = lwtm_pkg::ROOT_TBL[{iter_reg, 5'b0} +: 32];
            end
            ST_KEY: begin
                mul_a = {16'b0, key_reg};
                mul_b = m_reg;
            end
            ST_LW: begin
                mul_a = ws_reg;
                mul_b = {24'b0, item_reg.item.white_factor};
            end
            ST_AL: begin
                mul_a = gain_reg;
                mul_b = 32'(item_reg.lum);
            end
            ST_PP: begin
                mul_a = iter_reg[1] ? ld_reg[63:32] : ld_reg[31:0];
                mul_b = iter_reg[0] ? h_reg[63:32] : h_reg[31:0];
            end
            ST_CH: begin
                mul_a = {3'b0, r_reg};
                mul_b = 32'(ch_c);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // shared divider launch
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        case (state_reg)
            ST_CLOSE: begin
                div_start = (cnt_reg != '0);
                div_dvd   = 64'(ls_mag) + (ls_neg ? 64'(cnt_reg) - 64'd1 : 64'd0);
                div_dsr   = 64'(cnt_reg);
            end
            ST_WS_GO: begin
                div_start = (max_reg != '0);
                div_dvd   = {27'b0, white_reg, 21'b0} + 64'(max_reg >> 1);
                div_dsr   = 64'(max_reg);
            end
            ST_D1_GO: begin
                div_start = 1'b1;
                div_dvd   = {8'b0, al_reg, 16'b0};
                div_dsr   = {24'b0, lw_reg};
            end
            ST_KQ_GO: begin
                div_start = 1'b1;
                div_dvd   = {8'b0, d1_reg, 16'b0};
                div_dsr   = {24'b0, lw_reg};
            end
            ST_LD_GO: begin
                div_start = 1'b1;
                div_dvd   = {7'b0, 41'(kq_reg) + 41'd65536, 16'b0};
                div_dsr   = {23'b0, 41'(al_reg) + 41'd65536};
            end
            ST_H_GO: begin
                div_start = 1'b1;
                div_dvd   = {16'b0, gain_reg, 16'b0};
                div_dsr   = {24'b0, lw_reg};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    lwtm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer, statistics, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            key_reg     <= lwtm_pkg::KEY_RESET;
            white_reg   <= lwtm_pkg::WHITE_RESET;
            max_reg     <= '0;
            lsum_reg    <= '0;
            cnt_reg     <= '0;
            gain_reg    <= '0;
            ws_reg      <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    lwtm_pkg::REG_KEY:   key_reg   <= cfg_wdata;
                    lwtm_pkg::REG_WHITE: white_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // result leaves on its transfer unless the emit state refills it
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_data;
                        state_reg <= (q_data.item.cmd == lwtm_pkg::CMD_MAP) ? ST_LW : ST_STAT;
                    end
                end

                // statistics pass
                ST_STAT: begin
                    if (item_reg.lum > max_reg) begin
                        max_reg <= item_reg.lum;
                    end
                    if (item_reg.lum != '0 && cnt_reg < lwtm_pkg::COUNT_CAP) begin
                        m_reg     <= norm;
                        p_reg     <= msb;
                        frac_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_LOG;
                    end else begin
                        state_reg <= item_reg.item.frame_end ? ST_CLOSE : ST_IDLE;
                    end
                end
                ST_LOG: begin
                    if (sq[31]) begin
                        frac_reg[4'd15 - iter_reg] <= 1'b1;
                        m_reg <= {1'b0, sq[31:1]};
                    end else begin
                        m_reg <= sq;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 4'd15) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    lsum_reg  <= lsum_reg + $signed(log_val);
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= item_reg.item.frame_end ? ST_CLOSE : ST_IDLE;
                end
                ST_CLOSE: begin
                    if (cnt_reg == '0) begin
                        gain_reg  <= {12'b0, key_reg, 4'b0};
                        state_reg <= ST_WS_GO;
                    end else begin
                        state_reg <= ST_MEAN_WAIT;
                    end
                end
                ST_MEAN_WAIT: begin
                    if (div_done) begin
                        n_reg     <= ls_neg ? div_q[23:0] : 24'(-div_q[23:0]);
                        m_reg     <= 32'h4000_0000;
                        iter_reg  <= '0;
                        state_reg <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    if (n_reg[4'd15 - iter_reg]) begin
                        m_reg <= mul_p[61:30];
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 4'd15) begin
                        state_reg <= ST_KEY;
                    end
                end
                ST_KEY: begin
                    if (exp_ip > 8'sd25) begin
                        gain_reg <= 32'hFFFF_FFFF;
                    end else if (exp_s > 9'sd62) begin
                        gain_reg <= '0;
                    end else begin
                        gain_reg <= (exp_rnd[63:32] != '0) ? 32'hFFFF_FFFF : exp_rnd[31:0];
                    end
                    state_reg <= ST_WS_GO;
                end
                ST_WS_GO: begin
                    if (max_reg == '0) begin
                        ws_reg    <= '0;
                        max_reg   <= '0;
                        lsum_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_WS_WAIT;
                    end
                end
                ST_WS_WAIT: begin
                    if (div_done) begin
                        ws_reg    <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                        max_reg   <= '0;
                        lsum_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end

                // mapping pass
                ST_LW: begin
                    lw_reg    <= mul_p[39:0];
                    state_reg <= ST_AL;
                end
                ST_AL: begin
                    res_reg.out_last <= item_reg.item.frame_end;
                    if (item_reg.lum == '0 || lw_reg == '0) begin
                        res_reg.out_zero <= '0;
                        res_reg.out_one  <= '0;
                        res_reg.out_two  <= '0;
                        state_reg        <= ST_EMIT;
                    end else begin
                        al_reg    <= (al_sh > 45'(lwtm_pkg::CAP40)) ? lwtm_pkg::CAP40
                                                                    : al_sh[39:0];
                        state_reg <= ST_D1_GO;
                    end
                end
                ST_D1_GO: state_reg <= ST_D1_WAIT;
                ST_D1_WAIT: begin
                    if (div_done) begin
                        d1_reg    <= cap40(div_q);
                        state_reg <= ST_KQ_GO;
                    end
                end
                ST_KQ_GO: state_reg <= ST_KQ_WAIT;
                ST_KQ_WAIT: begin
                    if (div_done) begin
                        kq_reg    <= cap40(div_q);
                        state_reg <= ST_LD_GO;
                    end
                end
                ST_LD_GO: state_reg <= ST_LD_WAIT;
                ST_LD_WAIT: begin
                    if (div_done) begin
                        ld_reg    <= div_q;
                        state_reg <= ST_H_GO;
                    end
                end
                ST_H_GO: state_reg <= ST_H_WAIT;
                ST_H_WAIT: begin
                    if (div_done) begin
                        h_reg     <= div_q;
                        acc_reg   <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_PP;
                    end
                end
                ST_PP: begin
                    acc_reg  <= acc_reg + pp_ext;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 4'd3) begin
                        state_reg <= ST_R;
                    end
                end
                ST_R: begin
                    // anything at or above 2^28 saturates every nonzero channel
                    r_reg     <= (acc_reg[95:44] != '0) ? 29'h1000_0000
                                                        : {1'b0, acc_reg[43:16]};
                    iter_reg  <= '0;
                    state_reg <= ST_CH;
                end
                ST_CH: begin
                    case (iter_reg)
                        4'd0:    res_reg.out_zero <= ch_o;
                        4'd1:    res_reg.out_one  <= ch_o;
                        default: res_reg.out_two  <= ch_o;
                    endcase
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 4'd2) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/local_white_tone_mapper_unit.sv
// Tone mapper with a per-pixel white map, run as two passes over a pixel stream.
// s_valid/s_ready/s_data carry pixels; cmd selects a statistics pixel or a
// mapping pixel, frame_end marks the last pixel of a pass. Statistics pixels
// give no result; each mapping pixel gives one transfer on m_valid/m_ready/m_data.
// cfg_wr_en/cfg_index/cfg_wdata write the key and white level.
// An input stage computes luminance and feeds a queue of FIFO_DEPTH pixels; the
// back end works one pixel at a time with one shared multiplier and one serial
// divider that yields a quotient bit per cycle while it is busy.
// In the back end a statistics pixel with zero luminance or a full count skips
// the log2; otherwise it takes 16 squaring steps for log2. The frame end adds
// two divisions and 16 exponent steps. A mapping pixel runs four divisions,
// which zero luminance or zero white skips. Each pixel also passes the
// registered input stage and the queue before it reaches the back end.
// Reset clears the queue, the statistics, the gain and the white scale, and
// restores the register defaults; s_ready is high the cycle after reset.
// While m_ready is low the result holds in the output register; the queue keeps
// taking pixels until it fills, then s_ready drops.
`timescale 1ns / 1ps

module local_white_tone_mapper_unit #(
    parameter int FIFO_DEPTH = lwtm_pkg::FIFO_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lwtm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lwtm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lwtm_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lwtm_pkg::out_item_t              m_data
);

    logic                  push_valid;
    logic                  push_ready;
    lwtm_pkg::queue_item_t push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    lwtm_pkg::queue_item_t pop_data;

    lwtm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lwtm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lwtm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (pop_valid),
        .q_pop     (pop_ready),
        .q_data    (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hdl/lwtm_checker.sv
`timescale 1ns / 1ps

module lwtm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lwtm_pkg::out_item_t m_data
);

    // a stalled result holds until the transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // reset empties the input stage and queue; the input is ready after it
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind local_white_tone_mapper_unit lwtm_checker u_lwtm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
